// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PTSQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ptsq assertion failed");

// checked at every edge, reset included
`define PTSQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ptsq assertion failed");

`endif

// ===== rtl/core/ptsq_pkg.sv =====
package ptsq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int TASK_ID_BITS  = 8;
    localparam int PRIORITY_BITS = 8;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_PICK    = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        SRC_NONE   = 2'd0,
        SRC_MAIN   = 2'd1,
        SRC_SHARED = 2'd2,
        SRC_LOCAL  = 2'd3
    } t_source;

    // one queue slot
    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic [TASK_ID_BITS-1:0]  id;
    } t_entry;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   place;
        t_entry entry;
    } t_cell_view;

    // command broadcast to every cell of a chain
    typedef struct packed {
        logic   ins;
        logic   pop;
        t_entry new_entry;
    } t_chain_ctl;

    // status of a chain seen by the top level
    typedef struct packed {
        logic   first_valid;
        logic   second_valid;
        logic   full;
        t_entry head;
    } t_chain_status;

endpackage

// ===== rtl/core/ptsq_ifs.sv =====
// request channel
interface ptsq_req_if
    import ptsq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    t_opcode                  opcode;
    logic [TASK_ID_BITS-1:0]  task_id;
    logic [PRIORITY_BITS-1:0] priority_req;
    logic                     run_on_main;
    logic                     pinned;
    logic                     requester_is_main;

    modport source (output valid, opcode, task_id, priority_req, run_on_main, pinned,
                    requester_is_main, input ready);
    modport sink (input valid, opcode, task_id, priority_req, run_on_main, pinned,
                  requester_is_main, output ready);
endinterface

// result channel
interface ptsq_res_if
    import ptsq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    granted;
    logic [TASK_ID_BITS-1:0] granted_task;
    t_source                 source_queue;
    logic                    any_ready;
    logic                    dropped;

    modport source (output valid, granted, granted_task, source_queue, any_ready, dropped,
                    input ready);
    modport sink (input valid, granted, granted_task, source_queue, any_ready, dropped,
                  output ready);
endinterface

// ===== rtl/core/priority_task_scheduler_queues.sv =====
// channel   dir  modport  payload
// i_task    in   sink     opcode, task_id, priority_req, run_on_main, pinned, requester_is_main
// o_result  out  source   granted, granted_task, source_queue, any_ready, dropped
//
// one item per cycle while the output register is free or being taken: the queue cells update in
// the cycle an item is accepted and the result lands in a single output register
// each queue is a row of cells that shifts on insert or pop
// i_rst_n is synchronous, active low; all queues come up empty, no clearing pass
// a stalled result blocks i_task only while the output register is full and not taken
`include "assert_macros.svh"

module priority_task_scheduler_queues
    import ptsq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptsq_req_if.sink    i_task,
    ptsq_res_if.source  o_result
);

    t_chain_ctl    main_ctl, shared_ctl, local_ctl;
    t_chain_status main_st, shared_st, local_st;

    logic    accept;
    logic    is_enq;
    logic    is_pick;
    logic    to_local, to_main, to_shared;
    logic    pick_main, pick_shared, pick_local;
    logic    ins_main, ins_shared, ins_local;
    logic    main_after, shared_after, local_after;
    t_entry  new_entry;

    logic                    r_valid;
    logic                    r_granted;
    logic [TASK_ID_BITS-1:0] r_task;
    t_source                 r_source;
    logic                    r_any_ready;
    logic                    r_dropped;
    logic                    n_granted;
    logic [TASK_ID_BITS-1:0] n_task;
    t_source                 n_source;
    logic                    n_dropped;

    // no word is taken while reset is held
    assign i_task.ready = i_rst_n && (!r_valid || o_result.ready);
    assign accept       = i_task.valid && i_task.ready;
    assign is_enq       = accept && (i_task.opcode == OP_ENQUEUE);
    assign is_pick      = accept && (i_task.opcode == OP_PICK);

    // enqueue routing, pinned wins over run_on_main
    assign to_local  = i_task.pinned;
    assign to_main   = !i_task.pinned && i_task.run_on_main;
    assign to_shared = !i_task.pinned && !i_task.run_on_main;

    assign ins_main   = is_enq && to_main   && !main_st.full;
    assign ins_shared = is_enq && to_shared && !shared_st.full;
    assign ins_local  = is_enq && to_local  && !local_st.full;

    // pick order: main-only for a main requester, then shared, then local
    assign pick_main   = is_pick && i_task.requester_is_main && main_st.first_valid;
    assign pick_shared = is_pick && !pick_main && shared_st.first_valid;
    assign pick_local  = is_pick && !pick_main && !pick_shared && local_st.first_valid;

    assign new_entry = '{prio: i_task.priority_req, id: i_task.task_id};

    // local fifo is a chain with every priority equal, so inserts land at the tail
    assign main_ctl   = '{ins: ins_main,   pop: pick_main,   new_entry: new_entry};
    assign shared_ctl = '{ins: ins_shared, pop: pick_shared, new_entry: new_entry};
    assign local_ctl  = '{ins: ins_local,  pop: pick_local,
                          new_entry: '{prio: '0, id: i_task.task_id}};

    ptsq_chain u_main (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (main_ctl),
        .o_status (main_st)
    );

    ptsq_chain u_shared (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (shared_ctl),
        .o_status (shared_st)
    );

    ptsq_chain u_local (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (local_ctl),
        .o_status (local_st)
    );

    // occupancy after this step
    assign main_after   = ins_main   || (pick_main   ? main_st.second_valid
                                                     : main_st.first_valid);
    assign shared_after = ins_shared || (pick_shared ? shared_st.second_valid
                                                     : shared_st.first_valid);
    assign local_after  = ins_local  || (pick_local  ? local_st.second_valid
                                                     : local_st.first_valid);

    // result word
    always_comb begin
        n_granted = 1'b0;
        n_task    = '0;
        n_source  = SRC_NONE;
        n_dropped = 1'b0;
        if (pick_main) begin
            n_granted = 1'b1;
            n_task    = main_st.head.id;
            n_source  = SRC_MAIN;
        end else if (pick_shared) begin
            n_granted = 1'b1;
            n_task    = shared_st.head.id;
            n_source  = SRC_SHARED;
        end else if (pick_local) begin
            n_granted = 1'b1;
            n_task    = local_st.head.id;
            n_source  = SRC_LOCAL;
        end else if (is_enq) begin
            n_dropped = (to_main   && main_st.full)   ||
                        (to_shared && shared_st.full) ||
                        (to_local  && local_st.full);
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_granted   <= n_granted;
            r_task      <= n_task;
            r_source    <= n_source;
            r_any_ready <= main_after || shared_after || local_after;
            r_dropped   <= n_dropped;
        end
    end

    assign o_result.valid        = r_valid;
    assign o_result.granted      = r_granted;
    assign o_result.granted_task = r_task;
    assign o_result.source_queue = r_source;
    assign o_result.any_ready    = r_any_ready;
    assign o_result.dropped      = r_dropped;

    // a pick while the shared or local queue holds a task is always served
    `PTSQ_ASSERT(a_pick_served, i_clk, i_rst_n,
        (is_pick && (shared_st.first_valid || local_st.first_valid))
            |=> (r_valid && r_granted))
    // an empty-handed result carries no task and no source
    `PTSQ_ASSERT(a_no_grant_clean, i_clk, i_rst_n,
        (r_valid && !r_granted) |-> (r_task == '0 && r_source == SRC_NONE))
    // an enqueue never grants and a pick never drops
    `PTSQ_ASSERT(a_enq_no_grant, i_clk, i_rst_n,
        accept |=> ($past(i_task.opcode) == OP_ENQUEUE) ? !r_granted : !r_dropped)

endmodule

// ===== rtl/core/ptsq_cell.sv =====
module ptsq_cell
    import ptsq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chain_ctl i_ctl,
    input  t_cell_view i_left,
    input  t_cell_view i_right,
    output t_cell_view o_view
);

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   place;

    // new entry belongs here or ahead: slot empty or strictly lower priority
    assign place = !r_valid || (r_entry.prio < i_ctl.new_entry.prio);

    // shift toward head on pop, toward tail behind the insert point
    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctl.pop) begin
            n_valid = i_right.valid;
            n_entry = i_right.entry;
        end else if (i_ctl.ins && place) begin
            if (i_left.place) begin
                n_valid = i_left.valid;
                n_entry = i_left.entry;
            end else begin
                n_valid = 1'b1;
                n_entry = i_ctl.new_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_view = '{valid: r_valid, place: place, entry: r_entry};

endmodule

// ===== rtl/core/ptsq_chain.sv =====
`include "assert_macros.svh"

module ptsq_chain
    import ptsq_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_chain_ctl    i_ctl,
    output t_chain_status o_status
);

    t_cell_view                views [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]    occ;

    // row of cells, head at index zero
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        t_cell_view left_view;
        t_cell_view right_view;

        if (i == 0) begin : g_head
            assign left_view = '{valid: 1'b0, place: 1'b0, entry: '0};
        end else begin : g_mid_l
            assign left_view = views[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_view = '{valid: 1'b0, place: 1'b1, entry: '0};
        end else begin : g_mid_r
            assign right_view = views[i+1];
        end

        ptsq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_left  (left_view),
            .i_right (right_view),
            .o_view  (views[i])
        );

        assign occ[i] = views[i].valid;
    end

    assign o_status = '{first_valid:  views[0].valid,
                        second_valid: views[1].valid,
                        full:         views[QUEUE_DEPTH-1].valid,
                        head:         views[0].entry};

    // occupied cells always form an unbroken run from the head
    `PTSQ_ASSERT(a_occ_packed, i_clk, i_rst_n, ((occ & (occ + 1'b1)) == '0))
    // an insert into a non-full chain adds exactly one entry
    `PTSQ_ASSERT(a_ins_grows, i_clk, i_rst_n,
        (i_ctl.ins && !i_ctl.pop && !occ[QUEUE_DEPTH-1])
            |=> ($countones(occ) == $past($countones(occ)) + 1))
    // a pop of a non-empty chain removes exactly one entry
    `PTSQ_ASSERT(a_pop_shrinks, i_clk, i_rst_n,
        (i_ctl.pop && occ[0]) |=> ($countones(occ) + 1 == $past($countones(occ))))

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ptsq_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 616;
    localparam int SETTLE_CYCLES  = 8;

    // one request word as the sender sees it
    typedef struct packed {
        t_opcode                  opcode;
        logic [TASK_ID_BITS-1:0]  task_id;
        logic [PRIORITY_BITS-1:0] prio;
        logic                     run_on_main;
        logic                     pinned;
        logic                     requester_is_main;
    } t_task_word;

    // one result word
    typedef struct packed {
        logic                    granted;
        logic [TASK_ID_BITS-1:0] granted_task;
        t_source                 source_queue;
        logic                    any_ready;
        logic                    dropped;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    ptsq_req_if task_ch ();
    ptsq_res_if result_ch ();

    priority_task_scheduler_queues dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_task   (task_ch),
        .o_result (result_ch)
    );

    // scheduler state as predicted
    t_entry                  main_q[$];
    t_entry                  shared_q[$];
    logic [TASK_ID_BITS-1:0] pinned_fifo[$];
    t_outcome                pending_outcomes[$];

    int src_idle_pct;
    int snk_idle_pct;
    int mismatch_count;
    int cycle_count;

    t_outcome got_word;
    t_outcome want_word;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // place behind every entry of equal or higher priority
    function automatic bit sorted_insert(ref t_entry q[$], input t_entry e);
        int pos;
        if (q.size() >= QUEUE_DEPTH) begin
            return 1'b0;
        end
        pos = 0;
        while (pos < q.size() && q[pos].prio >= e.prio) begin
            pos++;
        end
        q.insert(pos, e);
        return 1'b1;
    endfunction

    // next state and result for one accepted word
    function automatic t_outcome schedule_step(input t_task_word w);
        t_outcome r;
        t_entry   e;
        r = '0;
        e.prio = w.prio;
        e.id   = w.task_id;
        if (w.opcode == OP_ENQUEUE) begin
            // pinned wins over run_on_main
            if (w.pinned) begin
                if (pinned_fifo.size() >= QUEUE_DEPTH) begin
                    r.dropped = 1'b1;
                end else begin
                    pinned_fifo.insert(pinned_fifo.size(), w.task_id);
                end
            end else if (w.run_on_main) begin
                r.dropped = !sorted_insert(main_q, e);
            end else begin
                r.dropped = !sorted_insert(shared_q, e);
            end
        end else begin
            if (w.requester_is_main && main_q.size() > 0) begin
                e = main_q[0];
                main_q.delete(0);
                r.granted      = 1'b1;
                r.granted_task = e.id;
                r.source_queue = SRC_MAIN;
            end else if (shared_q.size() > 0) begin
                e = shared_q[0];
                shared_q.delete(0);
                r.granted      = 1'b1;
                r.granted_task = e.id;
                r.source_queue = SRC_SHARED;
            end else if (pinned_fifo.size() > 0) begin
                r.granted      = 1'b1;
                r.granted_task = pinned_fifo[0];
                r.source_queue = SRC_LOCAL;
                pinned_fifo.delete(0);
            end
        end
        r.any_ready = (main_q.size() + shared_q.size() + pinned_fifo.size()) != 0;
        return r;
    endfunction

    function automatic t_task_word make_word(input t_opcode op, input logic [7:0] id,
                                             input logic [7:0] prio, input logic on_main,
                                             input logic pin, input logic req_main);
        t_task_word w;
        w.opcode            = op;
        w.task_id           = id;
        w.prio              = prio;
        w.run_on_main       = on_main;
        w.pinned            = pin;
        w.requester_is_main = req_main;
        return w;
    endfunction

    // random word, priorities mostly clustered so ties are common
    function automatic t_task_word random_word(input int enq_pct);
        t_task_word w;
        int         sel;
        w.opcode  = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_PICK;
        w.task_id = 8'($urandom_range(255));
        sel = $urandom_range(3);
        case (sel)
            0: w.prio = 8'($urandom_range(255));
            1: w.prio = 8'($urandom_range(255, 252));
            default: w.prio = 8'($urandom_range(3));
        endcase
        w.run_on_main       = 1'($urandom_range(1));
        w.pinned            = ($urandom_range(3) == 0);
        w.requester_is_main = 1'($urandom_range(1));
        return w;
    endfunction

    // drive one word and predict it once accepted
    task automatic send_word(input t_task_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            task_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        task_ch.valid             <= 1'b1;
        task_ch.opcode            <= w.opcode;
        task_ch.task_id           <= w.task_id;
        task_ch.priority_req      <= w.prio;
        task_ch.run_on_main       <= w.run_on_main;
        task_ch.pinned            <= w.pinned;
        task_ch.requester_is_main <= w.requester_is_main;
        @(posedge i_clk);
        while (!task_ch.ready) begin
            @(posedge i_clk);
        end
        pending_outcomes.insert(pending_outcomes.size(), schedule_step(w));
    endtask

    // sender holds off until every result is back
    task automatic hold_until_drained();
        task_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got_word.granted      = result_ch.granted;
            got_word.granted_task = result_ch.granted_task;
            got_word.source_queue = result_ch.source_queue;
            got_word.any_ready    = result_ch.any_ready;
            got_word.dropped      = result_ch.dropped;
            if (pending_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected word: gnt=%0d task=%02h src=%0d rdy=%0d drop=%0d",
                             got_word.granted, got_word.granted_task, got_word.source_queue,
                             got_word.any_ready, got_word.dropped);
                end
            end else begin
                want_word = pending_outcomes[0];
                pending_outcomes.delete(0);
                if (got_word !== want_word) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("expected gnt=%0d task=%02h src=%0d rdy=%0d drop=%0d",
                                 want_word.granted, want_word.granted_task,
                                 want_word.source_queue, want_word.any_ready,
                                 want_word.dropped);
                        $display("actual   gnt=%0d task=%02h src=%0d rdy=%0d drop=%0d",
                                 got_word.granted, got_word.granted_task,
                                 got_word.source_queue, got_word.any_ready,
                                 got_word.dropped);
                    end
                end
            end
        end
        result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("priority_task_scheduler_queues test failed");
            $finish;
        end
    end

    // picks on empty queues from both requesters, junk in ignored fields
    task automatic test_empty_pick();
        send_word(make_word(OP_PICK, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1));
        send_word(make_word(OP_PICK, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    endtask

    // sorted order, equal priority ties, main routing and pinned precedence
    task automatic test_queue_routing();
        send_word(make_word(OP_ENQUEUE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
        send_word(make_word(OP_ENQUEUE, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0));
        send_word(make_word(OP_ENQUEUE, 8'h5A, 8'hFF, 1'b0, 1'b0, 1'b1));
        send_word(make_word(OP_ENQUEUE, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0));
        send_word(make_word(OP_ENQUEUE, 8'h01, 8'h80, 1'b1, 1'b0, 1'b1));
        send_word(make_word(OP_ENQUEUE, 8'hAA, 8'h7F, 1'b1, 1'b1, 1'b0));
        send_word(make_word(OP_ENQUEUE, 8'h55, 8'h00, 1'b0, 1'b1, 1'b1));
        send_word(make_word(OP_PICK, 8'h12, 8'h34, 1'b1, 1'b1, 1'b0));
        send_word(make_word(OP_PICK, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
        send_word(make_word(OP_PICK, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1));
        send_word(make_word(OP_PICK, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1));
        send_word(make_word(OP_PICK, 8'hC3, 8'h3C, 1'b0, 1'b0, 1'b0));
        send_word(make_word(OP_PICK, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
        send_word(make_word(OP_PICK, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
    endtask

    // bursts that fill, drain or churn the queues
    task automatic test_random_traffic(input int n_items, input int src_pct,
                                       input int snk_pct);
        int sent;
        int burst;
        int enq_pct;
        int sel;
        bit drained;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent    = 0;
        drained = 1'b0;
        while (sent < n_items) begin
            sel = $urandom_range(2);
            enq_pct = (sel == 0) ? 85 : (sel == 1) ? 50 : 15;
            burst = $urandom_range(48, 8);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                send_word(random_word(enq_pct));
                sent++;
            end
            if (!drained && sent >= n_items / 2) begin
                hold_until_drained();
                drained = 1'b1;
            end
        end
        hold_until_drained();
    endtask

    // sequence
    initial begin
        i_rst_n                   = 1'b0;
        task_ch.valid             = 1'b0;
        task_ch.opcode            = OP_ENQUEUE;
        task_ch.task_id           = '0;
        task_ch.priority_req      = '0;
        task_ch.run_on_main       = 1'b0;
        task_ch.pinned            = 1'b0;
        task_ch.requester_is_main = 1'b0;
        result_ch.ready           = 1'b0;
        src_idle_pct              = 29;
        snk_idle_pct              = 71;
        mismatch_count            = 0;
        cycle_count               = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pick();
        test_queue_routing();
        hold_until_drained();
        test_random_traffic(PHASE_ITEMS, 29, 71);
        test_random_traffic(PHASE_ITEMS, 71, 29);
        test_random_traffic(PHASE_ITEMS, 0, 0);

        task_ch.valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
            $display("priority_task_scheduler_queues test passed");
        end else begin
            $display("priority_task_scheduler_queues test failed");
        end
        $finish;
    end

endmodule
